// ===== hdl/ipdp_pkg.sv =====
// Package for the dotted-decimal IPv4 parser.
// Holds the character codes, the status type and the result struct.
// No dependencies; used by every module of the parser.
package ipdp_pkg;

    localparam int CHAR_W = 8;
    localparam int OCTET_W = 8;
    localparam int ADDR_W = 32;
    localparam int STORED_W = 24;
    localparam int POS_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
    localparam logic [POS_W-1:0] POS_LAST = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_TOO_MANY = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        t_status           status;
    } t_result;

endpackage

// ===== hdl/ipdp_parse.sv =====
// Parser state and per-character update for the dotted-decimal IPv4 parser.
// Computes the result of a string from the state when the end marker comes.
// Depends on ipdp_pkg.
module ipdp_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [ipdp_pkg::CHAR_W-1:0]   i_char,
    input  logic                          i_eot,
    output ipdp_pkg::t_result             o_result
);

    logic [ipdp_pkg::OCTET_W-1:0]  r_acc, n_acc;
    logic [ipdp_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [ipdp_pkg::STORED_W-1:0] r_stored, n_stored;
    ipdp_pkg::t_status             r_err, n_err;

    logic                          w_is_digit;
    logic [ipdp_pkg::OCTET_W-1:0]  w_digit;
    logic [ipdp_pkg::OCTET_W-1:0]  w_acc_next;
    logic [ipdp_pkg::ADDR_W-1:0]   w_acc_placed;

    assign w_is_digit = (i_char >= ipdp_pkg::CH_ZERO) && (i_char <= ipdp_pkg::CH_NINE);
    assign w_digit = i_char - ipdp_pkg::CH_ZERO;
    assign w_acc_next = (r_acc << 3) + (r_acc << 1) + w_digit;

    always_comb begin
        n_acc = r_acc;
        n_pos = r_pos;
        n_stored = r_stored;
        n_err = r_err;
        if (i_fire) begin
            if (i_eot) begin
                n_acc = '0;
                n_pos = '0;
                n_stored = '0;
                n_err = ipdp_pkg::ST_OK;
            end else if (r_err == ipdp_pkg::ST_OK) begin
                if (w_is_digit) begin
                    n_acc = w_acc_next;
                end else if (i_char == ipdp_pkg::CH_DOT) begin
                    if (r_pos == ipdp_pkg::POS_LAST) begin
                        n_err = ipdp_pkg::ST_TOO_MANY;
                    end else begin
                        case (r_pos)
                            2'd0:    n_stored[23:16] = r_stored[23:16] | r_acc;
                            2'd1:    n_stored[15:8] = r_stored[15:8] | r_acc;
                            default: n_stored[7:0] = r_stored[7:0] | r_acc;
                        endcase
                        n_pos = r_pos + 1'b1;
                        n_acc = '0;
                    end
                end else begin
                    n_err = ipdp_pkg::ST_BAD_CHAR;
                end
            end
        end
    end

    always_comb begin
        case (r_pos)
            2'd0:    w_acc_placed = {r_acc, 24'h0};
            2'd1:    w_acc_placed = {8'h0, r_acc, 16'h0};
            2'd2:    w_acc_placed = {16'h0, r_acc, 8'h0};
            default: w_acc_placed = {24'h0, r_acc};
        endcase
    end

    always_comb begin
        o_result.status = r_err;
        if (r_err == ipdp_pkg::ST_OK) begin
            o_result.address = {r_stored, 8'h0} | w_acc_placed;
        end else begin
            o_result.address = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pos <= '0;
            r_stored <= '0;
            r_err <= ipdp_pkg::ST_OK;
        end else begin
            r_acc <= n_acc;
            r_pos <= n_pos;
            r_stored <= n_stored;
            r_err <= n_err;
        end
    end

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_eot |=> r_acc == '0 && r_pos == '0 && r_stored == '0
            && r_err == ipdp_pkg::ST_OK)
        else $error("Parser state not cleared after the end marker.");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ipdp_pkg::ST_OK && !(i_fire && i_eot) |=> r_err == $past(r_err)
            && r_acc == $past(r_acc) && r_stored == $past(r_stored))
        else $error("Parser state changed after an error.");

    a_error_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.status != ipdp_pkg::ST_OK |-> o_result.address == '0)
        else $error("Nonzero address reported with an error status.");

endmodule

// ===== hdl/ipdp_out_buf.sv =====
// Output register for the dotted-decimal IPv4 parser results.
// Holds one result until the downstream side takes it. Depends on ipdp_pkg.
module ipdp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ipdp_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output ipdp_pkg::t_result o_result
);

    logic              r_vld;
    ipdp_pkg::t_result r_res;

    assign o_free = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_ready |-> !i_load)
        else $error("Pending result overwritten.");

endmodule

// ===== hdl/ipv4_dotted_decimal_parser.sv =====
// Top level of the dotted-decimal IPv4 parser: input register, parser, result register.
// Depends on ipdp_pkg, ipdp_parse and ipdp_out_buf.
// A result is loaded into the result register when its end-marker item leaves the input register.
// Throughput: one item per cycle; an end-marker item waits in the input register
// while an untaken result is held, and input ready then follows output ready.
// Reset (synchronous, active low) empties both registers and clears the parser.
module ipv4_dotted_decimal_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [ipdp_pkg::CHAR_W-1:0]           i_s_tdata,  // [7:0] character
    input  logic                                  i_s_tlast,  // end_of_text
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [ipdp_pkg::ADDR_W-1:0]           o_m_tdata,  // [31:0] address
    output logic [ipdp_pkg::STATUS_W-1:0]         o_m_tuser   // [1:0] status
);

    logic                          r_in_vld;
    logic [ipdp_pkg::CHAR_W-1:0]   r_in_char;
    logic                          r_in_eot;
    logic                          w_out_free;
    logic                          w_advance;
    ipdp_pkg::t_result             w_result;
    ipdp_pkg::t_result             w_out_result;

    assign w_advance = r_in_vld && (!r_in_eot || w_out_free);
    assign o_s_tready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_eot <= i_s_tlast;
        end
    end

    ipdp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_char   (r_in_char),
        .i_eot    (r_in_eot),
        .o_result (w_result)
    );

    ipdp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && r_in_eot),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_out_result)
    );

    assign o_m_tdata = w_out_result.address;
    assign o_m_tuser = w_out_result.status;

endmodule
